[design/spc_pkg.sv]
// Package for the status packet checker: verdict codes, packet offsets,
// header constants, the result struct and the byte-wide CRC-16 update.
// No dependencies.
`timescale 1ns / 1ps

package spc_pkg;

  // Byte counter width and its saturation value
  localparam int unsigned COUNT_W = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Packet layout (byte offsets from the start of the packet)
  localparam logic [COUNT_W-1:0] OFS_HDR0   = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] OFS_HDR1   = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] OFS_HDR2   = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] OFS_HDR3   = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] OFS_ID     = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] OFS_LEN_LO = COUNT_W'(5);
  localparam logic [COUNT_W-1:0] OFS_LEN_HI = COUNT_W'(6);
  localparam logic [COUNT_W-1:0] OFS_ERR    = COUNT_W'(8);
  localparam logic [COUNT_W-1:0] OFS_PAR_LO = COUNT_W'(9);
  localparam logic [COUNT_W-1:0] OFS_PAR_HI = COUNT_W'(10);

  // Header pattern FF FF FD 00
  localparam logic [7:0] HDR_SYNC = 8'hFF;
  localparam logic [7:0] HDR_MARK = 8'hFD;
  localparam logic [7:0] HDR_RSVD = 8'h00;

  // Size checks
  localparam int unsigned MIN_PACKET   = 11;
  localparam int unsigned LENGTH_EXTRA = 7;

  // CRC-16, polynomial 0x8005, init 0, no reflection
  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_TOO_SHORT = 3'd1,
    VERDICT_BAD_HDR   = 3'd2,
    VERDICT_BAD_LEN   = 3'd3,
    VERDICT_BAD_CRC   = 3'd4,
    VERDICT_DEV_ERR   = 3'd5
  } verdict_t;

  // One packet result, handed from the tracker to the output stage
  typedef struct packed {
    logic        valid;
    verdict_t    verdict;
    logic [7:0]  device_error;
    logic [7:0]  servo_id;
    logic [15:0] first_params;
  } result_t;

  // MSB-first CRC update over one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[design/spc_if.sv]
// Valid/ready channel interfaces for the status packet checker:
// received bytes in, packet results out. Depends on spc_pkg for nothing.
`timescale 1ns / 1ps

interface spc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source (output valid, output rx_byte, output last_byte, input ready);
  modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface spc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [7:0]  device_error;
  logic [7:0]  servo_id;
  logic [15:0] first_params;

  modport source (output valid, output verdict, output device_error, output servo_id,
                  output first_params, input ready);
  modport sink   (input valid, input verdict, input device_error, input servo_id,
                  input first_params, output ready);
endinterface

[design/spc_tracker.sv]
// Per-packet state of the status packet checker: byte count, header check,
// captured fields, delayed CRC. Produces the verdict on the last byte.
// Depends on spc_pkg.
`timescale 1ns / 1ps

module spc_tracker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      rx_byte,
  input  logic            last_byte,
  output spc_pkg::result_t res
);
  import spc_pkg::*;

  logic [COUNT_W-1:0] byte_count_r, byte_count_nxt;
  logic               header_good_r, header_good_nxt;
  logic [15:0]        length_word_r, length_word_nxt;
  logic [15:0]        crc_r, crc_nxt;
  logic [7:0]         dly0_r, dly1_r;
  logic [7:0]         id_r, id_nxt;
  logic [7:0]         err_r, err_nxt;
  logic [15:0]        params_r, params_nxt;
  logic [15:0]        check;
  logic [COUNT_W:0]   pkt_len;
  logic [COUNT_W:0]   len_expect;

  // Header check and field capture by byte position
  always_comb begin
    header_good_nxt = header_good_r;
    length_word_nxt = length_word_r;
    id_nxt          = id_r;
    err_nxt         = err_r;
    params_nxt      = params_r;
    case (byte_count_r)
      OFS_HDR0, OFS_HDR1: if (rx_byte != HDR_SYNC) header_good_nxt = 1'b0;
      OFS_HDR2:           if (rx_byte != HDR_MARK) header_good_nxt = 1'b0;
      OFS_HDR3:           if (rx_byte != HDR_RSVD) header_good_nxt = 1'b0;
      OFS_ID:             id_nxt = rx_byte;
      OFS_LEN_LO:         length_word_nxt = {length_word_r[15:8], rx_byte};
      OFS_LEN_HI:         length_word_nxt = {rx_byte, length_word_r[7:0]};
      OFS_ERR:            err_nxt = rx_byte;
      OFS_PAR_LO:         params_nxt = {params_r[15:8], rx_byte};
      OFS_PAR_HI:         params_nxt = {rx_byte, params_r[7:0]};
      default:            ;
    endcase
  end

  // CRC runs two bytes behind; the last two bytes form the received check word
  always_comb begin
    crc_nxt = (byte_count_r >= OFS_HDR2) ? crc16_byte(crc_r, dly1_r) : crc_r;
    check   = {rx_byte, dly0_r};
    byte_count_nxt = (byte_count_r != COUNT_MAX) ? byte_count_r + 1'b1 : byte_count_r;
  end

  // Verdict in priority order
  always_comb begin
    pkt_len    = {1'b0, byte_count_r} + 1'b1;
    len_expect = (COUNT_W+1)'(length_word_nxt) + (COUNT_W+1)'(LENGTH_EXTRA);
    res.valid        = accept & last_byte;
    res.device_error = err_nxt;
    res.servo_id     = id_nxt;
    res.first_params = params_nxt;
    if (pkt_len < (COUNT_W+1)'(MIN_PACKET)) begin
      res.verdict = VERDICT_TOO_SHORT;
    end else if (!header_good_nxt) begin
      res.verdict = VERDICT_BAD_HDR;
    end else if (len_expect != pkt_len) begin
      res.verdict = VERDICT_BAD_LEN;
    end else if (crc_nxt != check) begin
      res.verdict = VERDICT_BAD_CRC;
    end else if (err_nxt != 8'h00) begin
      res.verdict = VERDICT_DEV_ERR;
    end else begin
      res.verdict = VERDICT_OK;
    end
  end

  // State update; the last byte returns everything to the idle packet state
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      byte_count_r  <= '0;
      header_good_r <= 1'b1;
      length_word_r <= '0;
      crc_r         <= CRC_INIT;
      dly0_r        <= '0;
      dly1_r        <= '0;
      id_r          <= '0;
      err_r         <= '0;
      params_r      <= '0;
    end else if (accept) begin
      byte_count_r  <= byte_count_nxt;
      header_good_r <= header_good_nxt;
      length_word_r <= length_word_nxt;
      crc_r         <= crc_nxt;
      dly0_r        <= rx_byte;
      dly1_r        <= dly0_r;
      id_r          <= id_nxt;
      err_r         <= err_nxt;
      params_r      <= params_nxt;
    end
  end

endmodule

[design/status_packet_checker.sv]
// Top level of the status packet checker: byte input channel, per-packet
// tracker and registered result channel. Depends on spc_pkg, spc_if, spc_tracker.
`timescale 1ns / 1ps

// Usage:
//   in_ch  carries one received packet byte per transaction (rx_byte), with
//          last_byte set on the final byte of the packet.
//   out_ch carries one result transaction per packet: verdict, device error
//          byte (offset 8), servo id (offset 4) and parameter word (9..10).
//   Throughput: one byte per cycle while in_ch.ready is high. Each byte is
//   processed in the cycle it is accepted; the byte-wide CRC update and the
//   compares sit in front of the result register.
//   Output: the result is registered and appears on out_ch in the cycle
//   after the last byte is accepted.
//   Stall: the single result register holds a result until out_ch.ready;
//   in_ch.ready is low only while that register is full and not being taken.
//   Reset (rst_n low, synchronous): packet state returns to the start of a
//   packet, the result register is emptied.
//   A packet shorter than 11 bytes, including a single byte with last_byte,
//   gets verdict too short; byte offsets not received read as zero.

module status_packet_checker (
  input logic      clk,
  input logic      rst_n,
  spc_in_if.sink   in_ch,
  spc_out_if.source out_ch
);
  import spc_pkg::*;

  result_t     res;
  logic        in_accept;
  logic        out_valid_r;
  verdict_t    verdict_r;
  logic [7:0]  dev_err_r;
  logic [7:0]  servo_id_r;
  logic [15:0] params_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  spc_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .rx_byte   (in_ch.rx_byte),
    .last_byte (in_ch.last_byte),
    .res       (res)
  );

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, loaded on the last byte
  always_ff @(posedge clk) begin
    if (res.valid) begin
      verdict_r  <= res.verdict;
      dev_err_r  <= res.device_error;
      servo_id_r <= res.servo_id;
      params_r   <= res.first_params;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.verdict      = verdict_r;
  assign out_ch.device_error = dev_err_r;
  assign out_ch.servo_id     = servo_id_r;
  assign out_ch.first_params = params_r;

  // A new result only follows a last-byte transaction
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_accept && in_ch.last_byte))
    else $error("result appeared without a last-byte transaction");

  // An ok verdict never carries a device error
  a_ok_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && verdict_r == VERDICT_OK) |-> (dev_err_r == 8'h00))
    else $error("ok verdict with nonzero device error");

  // A stalled result is not overwritten
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(verdict_r)
      && $stable(params_r)))
    else $error("stalled result changed");

endmodule
